// ===== design/vpp_pkg.sv =====
// Shared constants, types and the job word for the vector plane projection core.
// No dependencies; every other file imports this package.
package vpp_pkg;

    localparam int CW   = 32;          // component width
    localparam int FB   = 16;          // fraction bits
    localparam int TW   = CW - 1;      // tolerance width
    localparam int PW   = 2 * CW;      // one product
    localparam int DW   = 2 * CW + 2;  // dot product
    localparam int LOW  = CW + 1;      // low slice of v.n for the split multiply
    localparam int HIW  = DW - LOW;    // high slice of v.n
    localparam int NUMW = CW + DW;     // axis * (v.n)
    localparam int NW   = NUMW + 1;    // twice |numerator|
    localparam int QB   = CW + 3;      // quotient bits kept before saturation
    localparam int LIMW = TW + FB;     // tolerance scaled for the in-plane test

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NORM_ZERO = 2'd1,
        ST_DIR_ZERO  = 2'd2,
        ST_DIR_PLANE = 2'd3
    } t_status;

    typedef enum logic {
        REQ_OBLIQUE = 1'b0,
        REQ_ORTHO   = 1'b1
    } t_req;

    typedef struct packed {
        t_status               status;
        logic [2:0][CW-1:0]    v;
        logic [2:0][CW-1:0]    axis;
        logic [DW-1:0]         den;
        logic [DW-1:0]         vn;
    } t_job;

endpackage

// ===== design/vpp_front.sv =====
// Front end: registers the word, forms the four dot products and classifies it.
// Depends on vpp_pkg.
module vpp_front
    import vpp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_req_type,
    input  logic [2:0][CW-1:0]    i_vec,
    input  logic [2:0][CW-1:0]    i_norm,
    input  logic [2:0][CW-1:0]    i_dir,
    input  logic [TW-1:0]         i_tolerance,
    output logic                  o_valid,
    output t_job                  o_job
);

    logic                   r_vld1, r_vld2;
    logic                   r_req1, r_req2;
    logic [2:0][CW-1:0]     r_v1, r_n1, r_d1, r_v2, r_n2, r_d2;
    logic signed [PW-1:0]   r_pnn [3];
    logic signed [PW-1:0]   r_pdd [3];
    logic signed [PW-1:0]   r_pdn [3];
    logic signed [PW-1:0]   r_pvn [3];
    logic [2*TW-1:0]        r_tol2;
    logic [LIMW-1:0]        r_lim;
    logic signed [DW-1:0]   r_nn, r_dd, r_dn, r_vn;

    logic signed [DW-1:0]   tol2_x, lim_x, dn_abs;
    t_status                status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req1 <= i_req_type;
        r_v1   <= i_vec;
        r_n1   <= i_norm;
        r_d1   <= i_dir;
        r_tol2 <= i_tolerance * i_tolerance;
        r_lim  <= {i_tolerance, {FB{1'b0}}};
        for (int i = 0; i < 3; i++) begin
            r_pnn[i] <= $signed(i_norm[i]) * $signed(i_norm[i]);
            r_pdd[i] <= $signed(i_dir[i]) * $signed(i_dir[i]);
            r_pdn[i] <= $signed(i_dir[i]) * $signed(i_norm[i]);
            r_pvn[i] <= $signed(i_vec[i]) * $signed(i_norm[i]);
        end
        r_req2 <= r_req1;
        r_v2   <= r_v1;
        r_n2   <= r_n1;
        r_d2   <= r_d1;
        r_nn   <= DW'(r_pnn[0]) + DW'(r_pnn[1]) + DW'(r_pnn[2]);
        r_dd   <= DW'(r_pdd[0]) + DW'(r_pdd[1]) + DW'(r_pdd[2]);
        r_dn   <= DW'(r_pdn[0]) + DW'(r_pdn[1]) + DW'(r_pdn[2]);
        r_vn   <= DW'(r_pvn[0]) + DW'(r_pvn[1]) + DW'(r_pvn[2]);
    end

    assign tol2_x = $signed(DW'(r_tol2));
    assign lim_x  = $signed(DW'(r_lim));
    assign dn_abs = r_dn[DW-1] ? -r_dn : r_dn;

    always_comb begin
        if (r_nn <= tol2_x) begin
            status = ST_NORM_ZERO;
        end else if (r_req2 == REQ_OBLIQUE && r_dd <= tol2_x) begin
            status = ST_DIR_ZERO;
        end else if (r_req2 == REQ_OBLIQUE && dn_abs <= lim_x) begin
            status = ST_DIR_PLANE;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_job.status = status;
        o_job.v      = r_v2;
        o_job.vn     = r_vn;
        if (r_req2 == REQ_OBLIQUE) begin
            o_job.axis = r_d2;
            o_job.den  = r_dn;
        end else begin
            o_job.axis = r_n2;
            o_job.den  = r_nn;
        end
    end

    assign o_valid = r_vld2;

endmodule

// ===== design/vpp_queue.sv =====
// Two-entry job queue between the front end and the divide pipeline.
// Depends on vpp_pkg.
module vpp_queue
    import vpp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output logic    o_empty,
    output logic    o_full,
    output t_job    o_job
);

    t_job        r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        do_pop;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (do_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(do_pop);
        end
    end

endmodule

// ===== design/vpp_back.sv =====
// Back end: split multiply, restoring divide one quotient bit per stage,
// rounding and saturation. Depends on vpp_pkg.
module vpp_back
    import vpp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_job               i_job,
    output logic               o_valid,
    output logic [2:0][CW-1:0] o_res,
    output t_status            o_status
);

    localparam logic signed [QB+1:0] SAT_MAX = (QB+2)'((64'd1 << (CW-1)) - 64'd1);
    localparam logic signed [QB+1:0] SAT_MIN = -(QB+2)'(64'd1 << (CW-1));

    // multiply stage
    logic                  r_vm;
    t_job                  r_jm;
    logic signed [PW+1:0]  r_pl [3];
    logic signed [PW:0]    r_ph [3];
    // numerator stage
    logic                  r_vs;
    t_status               r_st_s;
    logic [2:0][CW-1:0]    r_v_s;
    logic signed [DW-1:0]  r_den_s;
    logic signed [NUMW-1:0] r_num [3];

    // divide pipeline, index 0 is the setup stage
    logic                  r_vd   [QB+1];
    t_status               r_st   [QB+1];
    logic [2:0][CW-1:0]    r_v    [QB+1];
    logic [DW-1:0]         r_dd   [QB+1];
    logic [2:0]            r_neg  [QB+1];
    logic [2:0]            r_ovf  [QB+1];
    logic [DW-1:0]         r_rem  [QB+1][3];
    logic [QB-1:0]         r_nlo  [QB+1][3];
    logic [QB-1:0]         r_q    [QB+1][3];

    logic [NW-1:0]         n_abs [3];
    logic [DW-1:0]         d_abs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
            r_vs <= 1'b0;
            for (int s = 0; s <= QB; s++) r_vd[s] <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_vm    <= i_valid;
            r_vs    <= r_vm;
            r_vd[0] <= r_vs;
            for (int s = 0; s < QB; s++) r_vd[s+1] <= r_vd[s];
            o_valid <= r_vd[QB];
        end
    end

    // split v.n so each product stays near two component widths
    always_ff @(posedge i_clk) begin
        r_jm <= i_job;
        for (int i = 0; i < 3; i++) begin
            r_pl[i] <= $signed(i_job.axis[i]) * $signed({1'b0, i_job.vn[LOW-1:0]});
            r_ph[i] <= $signed(i_job.axis[i]) * $signed(i_job.vn[DW-1:LOW]);
        end
        r_st_s  <= r_jm.status;
        r_v_s   <= r_jm.v;
        r_den_s <= $signed(r_jm.den);
        for (int i = 0; i < 3; i++) begin
            r_num[i] <= (NUMW'(r_ph[i]) <<< LOW) + NUMW'(r_pl[i]);
        end
    end

    assign d_abs = r_den_s[DW-1] ? DW'(-r_den_s) : DW'(r_den_s);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_abs[i] = r_num[i][NUMW-1] ? {NUMW'(-r_num[i]), 1'b0}
                                        : {NUMW'(r_num[i]), 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        logic [DW:0] trial;
        // setup: quotients wider than QB bits saturate, flag them
        r_st[0] <= r_st_s;
        r_v[0]  <= r_v_s;
        r_dd[0] <= d_abs;
        for (int i = 0; i < 3; i++) begin
            r_neg[0][i] <= r_num[i][NUMW-1] ^ r_den_s[DW-1];
            r_ovf[0][i] <= (DW+QB)'(n_abs[i]) >= ((DW+QB)'(d_abs) << QB);
            r_rem[0][i] <= DW'(n_abs[i] >> QB);
            r_nlo[0][i] <= n_abs[i][QB-1:0];
            r_q[0][i]   <= '0;
        end
        // one quotient bit per stage
        for (int s = 0; s < QB; s++) begin
            r_st[s+1]  <= r_st[s];
            r_v[s+1]   <= r_v[s];
            r_dd[s+1]  <= r_dd[s];
            r_neg[s+1] <= r_neg[s];
            r_ovf[s+1] <= r_ovf[s];
            for (int i = 0; i < 3; i++) begin
                trial = {r_rem[s][i], r_nlo[s][i][QB-1-s]};
                r_nlo[s+1][i] <= r_nlo[s][i];
                if (trial >= {1'b0, r_dd[s]}) begin
                    r_rem[s+1][i] <= DW'(trial - {1'b0, r_dd[s]});
                    r_q[s+1][i]   <= {r_q[s][i][QB-2:0], 1'b1};
                end else begin
                    r_rem[s+1][i] <= DW'(trial);
                    r_q[s+1][i]   <= {r_q[s][i][QB-2:0], 1'b0};
                end
            end
        end
    end

    // round half away from zero, subtract, clamp
    always_ff @(posedge i_clk) begin
        logic [QB:0]           t_rnd;
        logic signed [QB:0]    q_sgn;
        logic signed [QB+1:0]  diff;
        o_status <= r_st[QB];
        for (int i = 0; i < 3; i++) begin
            t_rnd = ({1'b0, r_q[QB][i]} + (QB+1)'(1)) >> 1;
            q_sgn = r_neg[QB][i] ? -$signed(t_rnd) : $signed(t_rnd);
            diff  = (QB+2)'($signed(r_v[QB][i])) - (QB+2)'(q_sgn);
            if (r_st[QB] != ST_OK) begin
                o_res[i] <= r_v[QB][i];
            end else if (r_ovf[QB][i]) begin
                o_res[i] <= r_neg[QB][i] ? CW'(SAT_MAX) : CW'(SAT_MIN);
            end else if (diff > SAT_MAX) begin
                o_res[i] <= CW'(SAT_MAX);
            end else if (diff < SAT_MIN) begin
                o_res[i] <= CW'(SAT_MIN);
            end else begin
                o_res[i] <= diff[CW-1:0];
            end
        end
    end

endmodule

// ===== design/vector_plane_projection_core.sv =====
// Top level of the vector plane projection core: tolerance register, front end,
// job queue and divide back end. Depends on vpp_pkg, vpp_front, vpp_queue, vpp_back.
//
// Takes one word per clock while busy is low and returns exactly one result per
// word, in order, on o_done for a single cycle; the receiver cannot stall.
// The back end's restoring divider resolves one quotient bit per pipeline stage.
// Write i_cfg_wdata with i_cfg_we only while no word is in flight.
module vector_plane_projection_core
    import vpp_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  logic           i_cfg_we,
    input  logic [TW-1:0]  i_cfg_wdata,
    input  logic           i_req_type,
    input  logic [CW-1:0]  i_vec_x,
    input  logic [CW-1:0]  i_vec_y,
    input  logic [CW-1:0]  i_vec_z,
    input  logic [CW-1:0]  i_norm_x,
    input  logic [CW-1:0]  i_norm_y,
    input  logic [CW-1:0]  i_norm_z,
    input  logic [CW-1:0]  i_dir_x,
    input  logic [CW-1:0]  i_dir_y,
    input  logic [CW-1:0]  i_dir_z,
    output logic           o_done,
    output logic [CW-1:0]  o_res_x,
    output logic [CW-1:0]  o_res_y,
    output logic [CW-1:0]  o_res_z,
    output logic [1:0]     o_status
);

    logic [TW-1:0]       r_tolerance;
    logic                accept;
    logic                f_valid, q_empty, q_full;
    t_job                f_job, q_job;
    logic [2:0][CW-1:0]  res;
    t_status             status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= TW'(1);
        end else if (i_cfg_we) begin
            r_tolerance <= i_cfg_wdata;
        end
    end

    assign busy   = q_full;
    assign accept = start && !busy;

    vpp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_req_type  (i_req_type),
        .i_vec       ({i_vec_z, i_vec_y, i_vec_x}),
        .i_norm      ({i_norm_z, i_norm_y, i_norm_x}),
        .i_dir       ({i_dir_z, i_dir_y, i_dir_x}),
        .i_tolerance (r_tolerance),
        .o_valid     (f_valid),
        .o_job       (f_job)
    );

    vpp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_job   (f_job),
        .i_pop   (1'b1),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_job   (q_job)
    );

    vpp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!q_empty),
        .i_job    (q_job),
        .o_valid  (o_done),
        .o_res    (res),
        .o_status (status)
    );

    assign o_res_x  = res[0];
    assign o_res_y  = res[1];
    assign o_res_z  = res[2];
    assign o_status = status;

endmodule

// ===== tb/vector_plane_projection_core_tb.sv =====
// Self-checking testbench for vector_plane_projection_core: a scoreboard class
// predicts each projection and checks every result word. Depends on vpp_pkg.
module vector_plane_projection_core_tb;
    import vpp_pkg::*;

    typedef logic signed [191:0] wide_t;

    typedef struct packed {
        t_req              req;
        logic [2:0][CW-1:0] v;
        logic [2:0][CW-1:0] n;
        logic [2:0][CW-1:0] d;
    } proj_word_t;

    typedef struct packed {
        logic [2:0][CW-1:0] r;
        t_status            status;
    } proj_result_t;

    class proj_board;
        proj_result_t pending[$];
        logic [TW-1:0] tol = 1;
        int errors = 0;
        int results = 0;
        int status_seen[4] = '{0, 0, 0, 0};

        function wide_t sx(logic [CW-1:0] a);
            wide_t w;
            w = $signed(a);
            return w;
        endfunction

        function wide_t dot(logic [2:0][CW-1:0] a, logic [2:0][CW-1:0] b);
            return sx(a[0]) * sx(b[0]) + sx(a[1]) * sx(b[1]) + sx(a[2]) * sx(b[2]);
        endfunction

        // Round num/den to nearest, halves away from zero.
        function wide_t div_round(wide_t num, wide_t den);
            wide_t an, ad, t;
            an = num < 0 ? -num : num;
            ad = den < 0 ? -den : den;
            t = ((2 * an) / ad + 1) >>> 1;
            return ((num < 0) != (den < 0)) ? -t : t;
        endfunction

        function void note(proj_word_t w);
            proj_result_t e;
            wide_t tw, tol2, nn, dd, dn, den, vn, q, diff, adn;
            logic [2:0][CW-1:0] axis;
            tw = wide_t'(tol);
            tol2 = tw * tw;
            nn = dot(w.n, w.n);
            den = nn;
            axis = w.n;
            e.status = ST_OK;
            if (nn <= tol2) begin
                e.status = ST_NORM_ZERO;
            end else if (w.req == REQ_OBLIQUE) begin
                dd = dot(w.d, w.d);
                dn = dot(w.d, w.n);
                adn = dn < 0 ? -dn : dn;
                if (dd <= tol2) begin
                    e.status = ST_DIR_ZERO;
                end else if (adn <= (tw <<< FB)) begin
                    e.status = ST_DIR_PLANE;
                end else begin
                    axis = w.d;
                    den = dn;
                end
            end
            if (e.status != ST_OK) begin
                e.r = w.v;
            end else begin
                vn = dot(w.v, w.n);
                for (int i = 0; i < 3; i++) begin
                    q = div_round(sx(axis[i]) * vn, den);
                    diff = sx(w.v[i]) - q;
                    if (diff > wide_t'(32'sh7fffffff)) e.r[i] = 32'h7fffffff;
                    else if (diff < -wide_t'(64'sh80000000)) e.r[i] = 32'h80000000;
                    else e.r[i] = diff[CW-1:0];
                end
            end
            pending.push_back(e);
        endfunction

        function void check(proj_result_t a);
            proj_result_t e;
            results++;
            status_seen[a.status]++;
            if (pending.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            for (int i = 0; i < 3; i++) begin
                if (a.r[i] !== e.r[i]) begin
                    $error("res_%0s: expected %0d, got %0d", i == 0 ? "x" : i == 1 ? "y" : "z",
                           $signed(e.r[i]), $signed(a.r[i]));
                    errors++;
                end
            end
            if (a.status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, a.status);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    logic busy;
    logic i_cfg_we = 0;
    logic [TW-1:0] i_cfg_wdata = '0;
    proj_word_t word = '0;
    logic o_done;
    logic [CW-1:0] o_res_x, o_res_y, o_res_z;
    logic [1:0] o_status;

    proj_board board = new();
    int idle_pct = 0;
    int stall_cycles = 0;
    int words_sent = 0;

    always #5 i_clk = ~i_clk;

    vector_plane_projection_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_req_type(word.req),
        .i_vec_x(word.v[0]), .i_vec_y(word.v[1]), .i_vec_z(word.v[2]),
        .i_norm_x(word.n[0]), .i_norm_y(word.n[1]), .i_norm_z(word.n[2]),
        .i_dir_x(word.d[0]), .i_dir_y(word.d[1]), .i_dir_z(word.d[2]),
        .o_done(o_done), .o_res_x(o_res_x), .o_res_y(o_res_y), .o_res_z(o_res_z),
        .o_status(o_status)
    );

    // Note accepted words, check results, and guard against a hang.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) board.note(word);
            if (o_done) board.check({o_res_z, o_res_y, o_res_x, t_status'(o_status)});
            if ((start && !busy) || o_done) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
            if (stall_cycles > 3000) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_word(proj_word_t w);
        int gap;
        word <= w;
        start <= 1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        words_sent++;
        if ($urandom_range(99) < idle_pct) begin
            start <= 0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_tol(logic [TW-1:0] t);
        i_cfg_we <= 1;
        i_cfg_wdata <= t;
        @(posedge i_clk);
        i_cfg_we <= 0;
        board.tol = t;
    endtask

    function automatic logic [CW-1:0] rand_comp();
        case ($urandom_range(7))
            0, 1: return $urandom;
            2: return '0;
            3: return 32'h80000000;
            4: return 32'h7fffffff;
            default: return $urandom_range(32'h200000) - 32'h100000;
        endcase
    endfunction

    function automatic proj_word_t rand_word();
        proj_word_t w;
        w.req = t_req'($urandom_range(1));
        for (int i = 0; i < 3; i++) begin
            w.v[i] = rand_comp();
            w.n[i] = rand_comp();
            w.d[i] = rand_comp();
        end
        case ($urandom_range(11))
            0: w.n = '0;
            1: w.d = '0;
            2: w.d = {32'h0, -w.n[0], w.n[1]};    // d.n = 0, lies in the plane
            3: w.n = {32'h0, 32'h0, 32'($urandom_range(3))};
            default: ;
        endcase
        return w;
    endfunction

    // Pack x, y, z components; x lands at index 0.
    function automatic logic [2:0][CW-1:0] v3(logic [CW-1:0] x, logic [CW-1:0] y,
                                              logic [CW-1:0] z);
        return {z, y, x};
    endfunction

    function automatic proj_word_t mk(t_req r, logic [2:0][CW-1:0] v,
                                      logic [2:0][CW-1:0] n, logic [2:0][CW-1:0] d);
        proj_word_t w;
        w.req = r; w.v = v; w.n = n; w.d = d;
        return w;
    endfunction

    localparam logic [CW-1:0] ONE = 32'h10000;
    localparam logic [CW-1:0] MAXC = 32'h7fffffff;
    localparam logic [CW-1:0] MINC = 32'h80000000;

    initial begin
        logic [TW-1:0] tols[6];
        tols = '{1, 0, 31'h7fffffff, 31'h10000, 31'($urandom), 31'($urandom_range(255))};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed words at the reset tolerance
        send_word(mk(REQ_ORTHO, v3(ONE, ONE, ONE), v3(ONE, 0, 0), '0));
        send_word(mk(REQ_OBLIQUE, v3(ONE, 2 * ONE, -ONE), v3(0, ONE, 0), v3(ONE, ONE, ONE)));
        send_word(mk(REQ_ORTHO, v3(MAXC, MINC, 5), '0, '0));
        send_word(mk(REQ_OBLIQUE, v3(7, 8, 9), v3(0, 0, ONE), '0));
        send_word(mk(REQ_OBLIQUE, v3(7, 8, 9), v3(0, 0, ONE), v3(ONE, ONE, 0)));
        send_word(mk(REQ_OBLIQUE, v3(7, 8, 9), v3(0, 0, 1), v3(0, 0, 1)));
        send_word(mk(REQ_OBLIQUE, v3(MAXC, MAXC, MAXC), v3(ONE, 0, 0), v3(2 * ONE, MAXC, 0)));
        send_word(mk(REQ_OBLIQUE, v3(MINC, MAXC, MINC), v3(ONE, 0, 0),
                     v3(2 * ONE, MAXC, MINC)));
        send_word(mk(REQ_ORTHO, v3(MAXC, MAXC, MAXC), v3(MINC, MINC, MINC), '0));
        send_word(mk(REQ_ORTHO, v3(MINC, MINC, MINC), v3(MAXC, MAXC, MAXC), '1));
        send_word(mk(REQ_OBLIQUE, v3(MINC, MINC, MINC), v3(MINC, MINC, MINC),
                     v3(MINC, MINC, MINC)));
        send_word(mk(REQ_OBLIQUE, v3(MAXC, MAXC, MAXC), v3(MAXC, MAXC, MAXC), v3(1, 0, 0)));
        send_word(mk(REQ_ORTHO, v3(3, 5, 7), v3(1, 0, 0), '0));
        send_word(mk(REQ_ORTHO, v3(3, 5, 7), v3(0, 1, 1), '0));
        send_word(mk(REQ_OBLIQUE, v3(1, 1, 1), v3(0, 0, 3), v3(0, 0, 2)));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_tol(tols[ph]);
            case (ph % 3)
                0: idle_pct = 26;
                1: idle_pct = 59;
                default: idle_pct = 0;
            endcase
            repeat (325) send_word(rand_word());
            drain();
        end

        $display("sent %0d words over six tolerance settings, %0d results checked",
                 words_sent, board.results);
        $display("status counts ok/normal/direction/in-plane: %0d %0d %0d %0d",
                 board.status_seen[0], board.status_seen[1], board.status_seen[2],
                 board.status_seen[3]);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
